// File: rtl/core/dcrf_pkg.sv
// Package: constants, codes and types shared by the disk controller register file.
package dcrf_pkg;

  // Geometry and buffer size
  localparam int unsigned HEADS             = 4;
  localparam int unsigned SECTORS_PER_TRACK = 16;
  localparam int unsigned BUFFER_WORDS      = 256;

  localparam int unsigned IDX_W = $clog2(BUFFER_WORDS);
  localparam int unsigned CNT_W = $clog2(BUFFER_WORDS + 1);
  localparam int unsigned BLK_W = 17;

  // Stream widths
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned S_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 40;

  // Item kinds
  typedef enum logic [2:0] {
    FUNC_BUS_READ  = 3'd0,
    FUNC_BUS_WRITE = 3'd1,
    FUNC_FILL      = 3'd2,
    FUNC_FETCH     = 3'd3,
    FUNC_READ_DONE = 3'd4
  } func_e;

  // Register selects (address masked by 036)
  localparam logic [4:0] ADDR_MASK   = 5'o36;
  localparam logic [4:0] ADDR_ID     = 5'o00;
  localparam logic [4:0] ADDR_ERR    = 5'o04;
  localparam logic [4:0] ADDR_SECTOR = 5'o06;
  localparam logic [4:0] ADDR_DATA   = 5'o10;
  localparam logic [4:0] ADDR_CYL    = 5'o12;
  localparam logic [4:0] ADDR_HEAD   = 5'o14;
  localparam logic [4:0] ADDR_CS     = 5'o16;
  localparam logic [4:0] ADDR_SI     = 5'o20;

  // Register bits and values
  localparam logic [15:0] ID_VALUE     = 16'o401;
  localparam logic [15:0] CMD_MASK     = 16'h00ff;
  localparam logic [7:0]  CMD_READ     = 8'o40;
  localparam logic [7:0]  CMD_WRITE    = 8'o60;
  localparam logic [15:0] CS_ERRBIT    = 16'h0100;
  localparam logic [15:0] CS_DR2       = 16'h0800;
  localparam logic [15:0] CS_INIT      = 16'h1000;
  localparam logic [15:0] CS_RDY       = 16'h4000;
  localparam logic [15:0] ERR_NOTFOUND = 16'h1000;
  localparam logic [15:0] SI_DONE      = 16'h0001;
  localparam logic [15:0] SI_SOFT_RST  = 16'h0008;
  localparam logic [15:0] SI_INTE      = 16'h0040;
  localparam logic [15:0] SI_DR1       = 16'h0080;
  localparam logic [15:0] SI_SLOW      = 16'h0100;
  localparam logic [15:0] SI_BUSY      = 16'h8000;

  // Storage requests
  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } req_e;

  // Control sequencer
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

endpackage

// File: rtl/core/disk_controller_register_file_core.sv
// Top level: disk controller register file with a sector buffer memory that has one
// write port and one registered read port. Each accepted item is one bus access or
// one storage word transfer and yields one result item. A DATA read that takes a word
// under a read command and a storage fetch pass the registered read port and the read
// state; other items go straight to the output register. The buffer has no reset: a
// word holds garbage until storage fills it or the bus writes it. Results wait in one
// output register; a new item is taken only when that register is empty or its result
// leaves at the same edge, and never while a buffer read is pending.
module disk_controller_register_file_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // reg_addr[4:0], bus_data[20:5], buf_index[28:21], fill_word[44:29], read_ok[45]
  input  logic [dcrf_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // func[2:0]
  input  logic [dcrf_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // read_data[15:0], irq[16], request[18:17], block_addr[35:19]
  output logic [dcrf_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import dcrf_pkg::*;

  // Input fields
  logic [2:0]  func;
  logic [4:0]  reg_addr;
  logic [4:0]  sel;
  logic [15:0] bus_data;
  logic [7:0]  buf_index;
  logic [15:0] fill_word;
  logic        read_ok;
  logic        idx_ok;

  assign func      = s_axis_tuser[2:0];
  assign reg_addr  = s_axis_tdata[4:0];
  assign bus_data  = s_axis_tdata[20:5];
  assign buf_index = s_axis_tdata[28:21];
  assign fill_word = s_axis_tdata[44:29];
  assign read_ok   = s_axis_tdata[45];
  assign sel       = reg_addr & ADDR_MASK;
  assign idx_ok    = (CNT_W'(buf_index) < CNT_W'(BUFFER_WORDS));

  // Controller registers
  logic [15:0]      err_q, err_d;
  logic [4:0]       sector_q, sector_d;
  logic [9:0]       cyl_q, cyl_d;
  logic [2:0]       head_q, head_d;
  logic [15:0]      cs_q, cs_d;
  logic [15:0]      si_q, si_d;
  logic [CNT_W-1:0] wc_q, wc_d;
  state_e           state_q, state_d;

  // Output register
  logic             m_valid_q, m_valid_d;
  logic [15:0]      rdata_q, rdata_d;
  logic             irq_q, irq_d;
  logic [1:0]       req_q, req_d;
  logic [BLK_W-1:0] blk_q, blk_d;

  // Sector buffer
  logic [15:0]      mem [BUFFER_WORDS];
  logic [15:0]      mem_rdata_q;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]      mem_wdata;

  logic             accept;
  logic [BLK_W-1:0] blk_addr;
  logic             wc_lt;
  logic [CNT_W-1:0] wc_inc;

  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign wc_lt         = (wc_q < CNT_W'(BUFFER_WORDS));
  assign wc_inc        = wc_q + CNT_W'(1);

  // Sector number from the current geometry registers
  assign blk_addr = (BLK_W'(cyl_q) * BLK_W'(HEADS) + BLK_W'(head_q)) * BLK_W'(SECTORS_PER_TRACK)
                    + BLK_W'(sector_q);

  // Decode the item, update registers, drive the buffer port
  always_comb begin
    err_d     = err_q;
    sector_d  = sector_q;
    cyl_d     = cyl_q;
    head_d    = head_q;
    cs_d      = cs_q;
    si_d      = si_q;
    wc_d      = wc_q;
    state_d   = state_q;
    m_valid_d = m_valid_q;
    rdata_d   = rdata_q;
    irq_d     = irq_q;
    req_d     = req_q;
    blk_d     = blk_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = wc_q[IDX_W-1:0];
    mem_raddr = wc_q[IDX_W-1:0];
    mem_wdata = bus_data;

    // Drop a result that was taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    if (state_q == ST_READ) begin
      // Buffer word arrives: complete the pending result
      rdata_d   = mem_rdata_q;
      m_valid_d = 1'b1;
      state_d   = ST_IDLE;
    end else if (accept) begin
      rdata_d = 16'h0000;
      req_d   = REQ_NONE;
      blk_d   = '0;
      case (func)
        FUNC_BUS_READ: begin
          case (sel)
            ADDR_ID: begin
              rdata_d = ID_VALUE;
              si_d    = si_q & ~SI_DR1;
            end
            ADDR_ERR:    rdata_d = err_q;
            ADDR_SECTOR: begin
              rdata_d = 16'(sector_q);
              si_d    = si_q & ~SI_DONE;
            end
            ADDR_DATA: begin
              if (cs_q[7:0] == CMD_READ) begin
                if (wc_lt) begin
                  mem_re  = 1'b1;
                  wc_d    = wc_inc;
                  state_d = ST_READ;
                end
                if (wc_d == CNT_W'(BUFFER_WORDS)) begin
                  si_d = (si_q | SI_DONE) & ~SI_DR1;
                  cs_d = cs_q & ~CS_DR2;
                end
              end
            end
            ADDR_CYL:  rdata_d = 16'(cyl_q);
            ADDR_HEAD: rdata_d = 16'(head_q);
            ADDR_CS: begin
              rdata_d = cs_q;
              si_d    = si_q & ~SI_DONE;
            end
            ADDR_SI:   rdata_d = si_q;
            default:   ;
          endcase
        end
        FUNC_BUS_WRITE: begin
          case (sel)
            ADDR_ID: si_d = si_q & ~SI_DR1;
            ADDR_SECTOR: begin
              sector_d = bus_data[4:0];
              si_d     = si_q & ~SI_DONE;
            end
            ADDR_DATA: begin
              if (cs_q[7:0] == CMD_WRITE) begin
                if (wc_lt) begin
                  mem_we = 1'b1;
                  wc_d   = wc_inc;
                end
                if (wc_d == CNT_W'(BUFFER_WORDS)) begin
                  req_d = REQ_WRITE;
                  blk_d = blk_addr;
                  si_d  = (si_q | SI_DONE) & ~SI_DR1;
                  cs_d  = cs_q & ~CS_DR2;
                end
              end
            end
            ADDR_CYL:  cyl_d  = bus_data[9:0];
            ADDR_HEAD: head_d = bus_data[2:0];
            ADDR_CS: begin
              cs_d  = (cs_q & ~CMD_MASK) | (bus_data & CMD_MASK);
              si_d  = si_q & ~SI_DONE;
              err_d = 16'h0000;
              if (bus_data[7:0] == CMD_READ) begin
                wc_d  = '0;
                req_d = REQ_READ;
                blk_d = blk_addr;
              end else if (bus_data[7:0] == CMD_WRITE) begin
                wc_d = '0;
              end
            end
            ADDR_SI: begin
              si_d = (si_q & (SI_DONE | SI_DR1 | SI_BUSY)) | (bus_data & (SI_INTE | SI_SLOW));
              if ((bus_data & SI_SOFT_RST) != 16'h0000) begin
                err_d    = 16'h0000;
                sector_d = '0;
                cyl_d    = '0;
                head_d   = '0;
                cs_d     = CS_INIT | CS_RDY;
                si_d     = SI_DONE | SI_INTE;
              end
            end
            default: ;
          endcase
        end
        FUNC_FILL: begin
          if (idx_ok) begin
            mem_we    = 1'b1;
            mem_waddr = buf_index[IDX_W-1:0];
            mem_wdata = fill_word;
          end
        end
        FUNC_FETCH: begin
          if (idx_ok) begin
            mem_re    = 1'b1;
            mem_raddr = buf_index[IDX_W-1:0];
            state_d   = ST_READ;
          end
        end
        FUNC_READ_DONE: begin
          if (cs_q[7:0] == CMD_READ) begin
            if (!read_ok) begin
              cs_d  = cs_q | CS_ERRBIT | CS_DR2;
              err_d = err_q | ERR_NOTFOUND;
            end else begin
              cs_d = cs_q | CS_DR2;
            end
            si_d = si_q | SI_DR1;
          end
        end
        default: ;
      endcase
      irq_d     = ((si_d & SI_INTE) != 16'h0000) && ((si_d & (SI_DONE | SI_DR1)) != 16'h0000);
      m_valid_d = (state_d == ST_IDLE);
    end
  end

  // Hold control and register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q     <= 16'h0000;
      sector_q  <= '0;
      cyl_q     <= '0;
      head_q    <= '0;
      cs_q      <= CS_INIT | CS_RDY;
      si_q      <= SI_DONE | SI_INTE;
      wc_q      <= '0;
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      err_q     <= err_d;
      sector_q  <= sector_d;
      cyl_q     <= cyl_d;
      head_q    <= head_d;
      cs_q      <= cs_d;
      si_q      <= si_d;
      wc_q      <= wc_d;
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
    irq_q   <= irq_d;
    req_q   <= req_d;
    blk_q   <= blk_d;
  end

  // Sector buffer: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'h0, blk_q, req_q, irq_q, rdata_q};

  // A pending buffer read leaves the output register empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !m_valid_q)
    else $error("result shown while buffer read pending");

  // Every accepted item leads to a result or a pending buffer read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_READ) || m_valid_q)
    else $error("accepted item produced no result");

  // Word count never passes the buffer size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q <= CNT_W'(BUFFER_WORDS))
    else $error("word count out of range");

endmodule

// File: test/testbench.sv
// Testbench for the disk controller register file: predicts every result and checks it.
`timescale 1ns / 1ps

module testbench;
  import dcrf_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam logic [2:0]  FUNC_TOP     = 3'd7;

  typedef struct packed {
    logic [15:0]      read_data;
    logic             irq;
    req_e             request;
    logic [BLK_W-1:0] block_addr;
  } response_t;

  // Register file tracker: mirrors the block and holds the responses still due
  class disk_reg_tracker;
    logic [15:0]      err_reg;
    logic [4:0]       sec_reg;
    logic [9:0]       cyl_reg;
    logic [2:0]       head_reg;
    logic [15:0]      cs_reg;
    logic [15:0]      si_reg;
    logic [CNT_W-1:0] count;
    logic [15:0]      mem [BUFFER_WORDS];
    response_t        responses_due[$];
    int unsigned      mismatches;

    function new();
      reset_regs();
      count = '0;
      foreach (mem[i]) mem[i] = '0;
      mismatches = 0;
    endfunction

    function void reset_regs();
      err_reg  = '0;
      sec_reg  = '0;
      cyl_reg  = '0;
      head_reg = '0;
      cs_reg   = CS_INIT | CS_RDY;
      si_reg   = SI_DONE | SI_INTE;
    endfunction

    function logic [BLK_W-1:0] sector_number();
      int unsigned b;
      b = (cyl_reg * HEADS + head_reg) * SECTORS_PER_TRACK + sec_reg;
      return b[BLK_W-1:0];
    endfunction

    // Buffer drained or filled: set done, drop both data requests
    function void close_buffer();
      si_reg |= SI_DONE;
      si_reg &= ~SI_DR1;
      cs_reg &= ~CS_DR2;
    endfunction

    function int unsigned pending();
      return responses_due.size();
    endfunction

    // Advance the mirror by one accepted item and queue its response
    function void take_item(input logic [2:0] f, input logic [4:0] addr,
                            input logic [15:0] wdata, input logic [7:0] idx,
                            input logic [15:0] fill, input logic ok);
      response_t  r;
      logic [4:0] sel;
      r = '0;
      r.request = REQ_NONE;
      sel = addr & ADDR_MASK;
      case (f)
        FUNC_BUS_READ: begin
          case (sel)
            ADDR_ID: begin
              r.read_data = ID_VALUE;
              si_reg &= ~SI_DR1;
            end
            ADDR_ERR: r.read_data = err_reg;
            ADDR_SECTOR: begin
              r.read_data = {11'b0, sec_reg};
              si_reg &= ~SI_DONE;
            end
            ADDR_DATA: begin
              if (cs_reg[7:0] == CMD_READ) begin
                if (count < BUFFER_WORDS) begin
                  r.read_data = mem[count[IDX_W-1:0]];
                  count++;
                end
                if (count == BUFFER_WORDS) close_buffer();
              end
            end
            ADDR_CYL:  r.read_data = {6'b0, cyl_reg};
            ADDR_HEAD: r.read_data = {13'b0, head_reg};
            ADDR_CS: begin
              r.read_data = cs_reg;
              si_reg &= ~SI_DONE;
            end
            ADDR_SI: r.read_data = si_reg;
            default: ;
          endcase
        end
        FUNC_BUS_WRITE: begin
          case (sel)
            ADDR_ID: si_reg &= ~SI_DR1;
            ADDR_SECTOR: begin
              sec_reg = wdata[4:0];
              si_reg &= ~SI_DONE;
            end
            ADDR_DATA: begin
              if (cs_reg[7:0] == CMD_WRITE) begin
                if (count < BUFFER_WORDS) begin
                  mem[count[IDX_W-1:0]] = wdata;
                  count++;
                end
                if (count == BUFFER_WORDS) begin
                  r.request    = REQ_WRITE;
                  r.block_addr = sector_number();
                  close_buffer();
                end
              end
            end
            ADDR_CYL:  cyl_reg = wdata[9:0];
            ADDR_HEAD: head_reg = wdata[2:0];
            ADDR_CS: begin
              cs_reg = (cs_reg & ~CMD_MASK) | (wdata & CMD_MASK);
              si_reg &= ~SI_DONE;
              err_reg = '0;
              if (cs_reg[7:0] == CMD_READ) begin
                count        = '0;
                r.request    = REQ_READ;
                r.block_addr = sector_number();
              end else if (cs_reg[7:0] == CMD_WRITE) begin
                count = '0;
              end
            end
            ADDR_SI: begin
              si_reg = (si_reg & (SI_DONE | SI_DR1 | SI_BUSY)) | (wdata & (SI_INTE | SI_SLOW));
              if ((wdata & SI_SOFT_RST) != '0) reset_regs();
            end
            default: ;
          endcase
        end
        FUNC_FILL: begin
          if (idx < BUFFER_WORDS) mem[idx] = fill;
        end
        FUNC_FETCH: begin
          if (idx < BUFFER_WORDS) r.read_data = mem[idx];
        end
        FUNC_READ_DONE: begin
          if (cs_reg[7:0] == CMD_READ) begin
            if (!ok) begin
              cs_reg  |= CS_ERRBIT;
              err_reg |= ERR_NOTFOUND;
            end
            si_reg |= SI_DR1;
            cs_reg |= CS_DR2;
          end
        end
        default: ;
      endcase
      r.irq = ((si_reg & SI_INTE) != '0) && ((si_reg & (SI_DONE | SI_DR1)) != '0);
      responses_due.push_back(r);
    endfunction

    task report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compare one result against the oldest response due
    task match_result(input logic [M_TDATA_W-1:0] d);
      response_t got;
      response_t want;
      got.read_data  = d[15:0];
      got.irq        = d[16];
      got.request    = req_e'(d[18:17]);
      got.block_addr = d[35:19];
      if (responses_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", d));
      end else begin
        want = responses_due.pop_front();
        if (got.read_data !== want.read_data)
          report_mismatch($sformatf("read_data %h, want %h", got.read_data, want.read_data));
        if (got.irq !== want.irq)
          report_mismatch($sformatf("irq %b, want %b", got.irq, want.irq));
        if (got.request !== want.request)
          report_mismatch($sformatf("request %0d, want %0d", got.request, want.request));
        if (got.block_addr !== want.block_addr)
          report_mismatch($sformatf("block_addr %h, want %h", got.block_addr, want.block_addr));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [S_TUSER_W-1:0] s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  disk_reg_tracker sb = new();
  int unsigned     src_idle_pct;
  int unsigned     snk_idle_pct;
  int unsigned     sink_hold;
  int unsigned     sent;

  disk_controller_register_file_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offer one item after a random gap, hold it until accepted, then note it
  task automatic send_item(input logic [2:0] f, input logic [4:0] addr,
                           input logic [15:0] wdata, input logic [7:0] idx,
                           input logic [15:0] fill, input logic ok);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {2'b00, ok, fill, idx, wdata, addr};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.take_item(f, addr, wdata, idx, fill, ok);
    sent++;
  endtask

  // Bus and storage items; fields the item does not use get random values
  task automatic bus_read(input logic [4:0] sel);
    send_item(FUNC_BUS_READ, sel | 5'($urandom_range(0, 1)), 16'($urandom), 8'($urandom),
              16'($urandom), 1'($urandom));
  endtask

  task automatic bus_write(input logic [4:0] sel, input logic [15:0] wdata);
    send_item(FUNC_BUS_WRITE, sel | 5'($urandom_range(0, 1)), wdata, 8'($urandom),
              16'($urandom), 1'($urandom));
  endtask

  task automatic fill_word(input logic [7:0] idx, input logic [15:0] w);
    send_item(FUNC_FILL, 5'($urandom), 16'($urandom), idx, w, 1'($urandom));
  endtask

  task automatic fetch_word(input logic [7:0] idx);
    send_item(FUNC_FETCH, 5'($urandom), 16'($urandom), idx, 16'($urandom), 1'($urandom));
  endtask

  task automatic read_done(input logic ok);
    send_item(FUNC_READ_DONE, 5'($urandom), 16'($urandom), 8'($urandom), 16'($urandom), ok);
  endtask

  // Drop valid and hold off until every response due has arrived
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Result side: check each accepted result, then pick the next ready level
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready) sb.match_result(m_axis_tdata);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned start;
    int unsigned n;
    bit          full;
    bit          force_full;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    src_idle_pct  = 16;
    snk_idle_pct  = 49;
    sink_hold     = 0;
    sent          = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Prime the whole buffer through a write command, then overrun the count
    bus_write(ADDR_CS, {8'hff, CMD_WRITE});
    repeat (BUFFER_WORDS + 1) bus_write(ADDR_DATA, 16'($urandom));

    // Directed: register extremes, unselected addresses, commands, SI reset
    bus_read(ADDR_ID);
    bus_write(ADDR_ID, 16'hffff);
    bus_write(ADDR_ERR, 16'hffff);
    bus_read(ADDR_ERR);
    bus_write(5'o02, 16'hffff);
    bus_read(5'o36);
    bus_write(ADDR_CYL, 16'hffff);
    bus_write(ADDR_HEAD, 16'hffff);
    bus_write(ADDR_SECTOR, 16'hffff);
    bus_read(ADDR_CYL);
    bus_read(ADDR_HEAD);
    bus_read(ADDR_SECTOR);
    bus_write(ADDR_CS, {8'hff, CMD_READ});
    read_done(1'b0);
    bus_read(ADDR_ERR);
    bus_read(ADDR_CS);
    bus_read(ADDR_SI);
    bus_read(ADDR_DATA);
    bus_write(ADDR_CS, 16'h00ff);
    read_done(1'b1);
    bus_read(ADDR_DATA);
    bus_write(ADDR_DATA, 16'h0000);
    fill_word(8'hff, 16'hffff);
    fetch_word(8'hff);
    fetch_word(8'h00);
    bus_write(ADDR_SI, 16'hffff);
    bus_write(ADDR_SI, 16'h0000);
    send_item(FUNC_TOP, 5'h1f, 16'hffff, 8'hff, 16'hffff, 1'b1);
    bus_write(ADDR_SI, SI_INTE);
    wait_drained();

    // Random: mostly well-formed sector transfers, some noise, three idle regimes
    start      = sent;
    force_full = 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 49 : 0;
      snk_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 16 : 0;
      if (phase == 2) sink_hold = HOLD_CYCLES;
      while (sent < start + (phase + 1) * RANDOM_ITEMS / 3) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // Sector read: address, command, storage fill, completion, drain
            bus_write(ADDR_CYL, 16'($urandom));
            bus_write(ADDR_HEAD, 16'($urandom));
            bus_write(ADDR_SECTOR, 16'($urandom));
            if ($urandom_range(0, 3) == 0) bus_write(ADDR_SI, 16'($urandom) & ~SI_SOFT_RST);
            bus_write(ADDR_CS, {8'($urandom), CMD_READ});
            n = $urandom_range(0, 6);
            repeat (n) fill_word(8'($urandom), 16'($urandom));
            if ($urandom_range(0, 7) == 0) bus_read(ADDR_CS);
            read_done($urandom_range(0, 3) != 0);
            full       = force_full || ($urandom_range(0, 3) == 0);
            force_full = 1'b0;
            n = full ? BUFFER_WORDS + $urandom_range(1, 3) : $urandom_range(1, 16);
            repeat (n) begin
              if ($urandom_range(0, 15) == 0)
                bus_read($urandom_range(0, 1) ? ADDR_SI : ADDR_CS);
              bus_read(ADDR_DATA);
            end
          end
          4, 5, 6: begin
            // Sector write: command, host fill, storage fetch
            bus_write(ADDR_CS, {8'($urandom), CMD_WRITE});
            full = ($urandom_range(0, 3) == 0);
            n = full ? BUFFER_WORDS + $urandom_range(1, 3) : $urandom_range(1, 16);
            repeat (n) bus_write(ADDR_DATA, 16'($urandom));
            n = $urandom_range(1, 8);
            repeat (n) fetch_word(8'($urandom));
          end
          default: begin
            // Noise: any kind, any field values
            n = $urandom_range(1, 8);
            repeat (n)
              send_item(3'($urandom_range(0, FUNC_TOP)), 5'($urandom), 16'($urandom),
                        8'($urandom), 16'($urandom), 1'($urandom));
          end
        endcase
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (sb.pending() != 0) sb.report_mismatch("responses left over at end");
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
